FILE: src/atp_pkg.sv
package atp_pkg;

  localparam int IN_W          = 16;
  localparam int SUM_W         = 32;
  localparam int ROOT_W        = 24;
  localparam int REM_W         = 27;
  localparam int CUR_W         = REM_W + 2;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORD_N        = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int IDX_W         = 5;
  localparam int CW            = 27;
  localparam int ACC_W         = 25;
  localparam int ATAN_W        = 22;
  localparam int FINE_W        = 16;
  localparam int DEG_W         = 8;
  localparam int PDEG_W        = 7;
  localparam int PROD_W        = 23;
  localparam int RECIP_W       = 24;
  localparam int RECIP_SH      = 31;
  localparam int US_W          = 16;

  localparam logic signed [FINE_W-1:0] FINE_LIMIT = 16'sd23040;
  // ceil(2^31 / 180): exact quotient for every product below 2^23
  localparam logic [RECIP_W-1:0] RECIP_180 = 24'd11930465;
  localparam logic [US_W-1:0] PULSE_MIN_RST  = 16'd1000;
  localparam logic [US_W-1:0] PULSE_SPAN_RST = 16'd1000;

  localparam logic REG_PULSE_MIN  = 1'b0;
  localparam logic REG_PULSE_SPAN = 1'b1;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic                   zero;
    logic [SUM_W-1:0]       s;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
  } root_t;

  typedef struct packed {
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
    logic                    xneg;
    logic                    xnz;
  } cord_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/atp_sqrt_cell.sv
module atp_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  atp_pkg::root_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output atp_pkg::root_t dn_data
);

  logic                           v_r;
  atp_pkg::root_t                 d_r;
  atp_pkg::root_t                 d_nxt;
  logic [atp_pkg::CUR_W-1:0]      cur;
  logic [atp_pkg::CUR_W-1:0]      trial;

  // one root bit per cell: bring down the next two operand bits, try 4q+1
  always_comb begin
    cur   = {up_data.rem, up_data.s[atp_pkg::SUM_W-1 -: 2]};
    trial = atp_pkg::CUR_W'({up_data.root, 2'b01});
    d_nxt = up_data;
    d_nxt.s = up_data.s << 2;
    if (cur >= trial) begin
      d_nxt.rem  = atp_pkg::REM_W'(cur - trial);
      d_nxt.root = {up_data.root[atp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = cur[atp_pkg::REM_W-1:0];
      d_nxt.root = {up_data.root[atp_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: src/atp_cordic_cell.sv
module atp_cordic_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [atp_pkg::IDX_W-1:0] stage_idx,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  atp_pkg::cord_t            up_data,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output atp_pkg::cord_t            dn_data
);

  logic                             v_r;
  atp_pkg::cord_t                   d_r;
  atp_pkg::cord_t                   d_nxt;
  logic signed [atp_pkg::CW-1:0]    dx;
  logic signed [atp_pkg::CW-1:0]    dy;
  logic signed [atp_pkg::ACC_W-1:0] at;

  // vectoring step: drive cy towards zero, floor shifts
  always_comb begin
    dx    = up_data.cy >>> stage_idx;
    dy    = up_data.cx >>> stage_idx;
    at    = signed'(atp_pkg::ACC_W'(atp_pkg::atan_entry(stage_idx)));
    d_nxt = up_data;
    if (!up_data.cy[atp_pkg::CW-1]) begin
      d_nxt.cx  = up_data.cx + dx;
      d_nxt.cy  = up_data.cy - dy;
      d_nxt.acc = up_data.acc + at;
    end else begin
      d_nxt.cx  = up_data.cx - dx;
      d_nxt.cy  = up_data.cy + dy;
      d_nxt.acc = up_data.acc - at;
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: src/accel_tilt_to_servo_pulse.sv
// Tilt of a three-axis accelerometer sample, atan2(x, sqrt(y^2+z^2)), in
// 1/256 degree and whole degrees, plus a servo pulse width
// pulse_min + deg*span/180 (negative tilt gives pulse_min, sum saturates at
// 65535). Fully pipelined: one sample per cycle while the output is not
// stalled (2 square/sum stages, 24 square-root cells, 16 CORDIC cells, 4
// output stages). Every stage holds its own valid bit and takes new data
// whenever it is empty or moving on, so bubbles close up and input requests
// keep flowing while the output register holds a result, until every stage
// is full. Write the registers only while the pipeline is empty.
module accel_tilt_to_servo_pulse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x, accel_y, accel_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // tilt_fine, tilt_deg, pulse_us
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int NR = atp_pkg::ROOT_W;
  localparam int NC = atp_pkg::CORD_N;

  // configuration
  logic [atp_pkg::US_W-1:0] pulse_min_r;
  logic [atp_pkg::US_W-1:0] pulse_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r  <= atp_pkg::PULSE_MIN_RST;
      pulse_span_r <= atp_pkg::PULSE_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        atp_pkg::REG_PULSE_MIN:  pulse_min_r  <= cfg_wdata;
        atp_pkg::REG_PULSE_SPAN: pulse_span_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // squares
  logic signed [atp_pkg::IN_W-1:0] in_x;
  logic signed [atp_pkg::IN_W-1:0] in_y;
  logic signed [atp_pkg::IN_W-1:0] in_z;
  logic signed [31:0]              ysq_full;
  logic signed [31:0]              zsq_full;
  logic                            f0_v_r;
  logic                            f0_rdy;
  logic signed [atp_pkg::IN_W-1:0] f0_x_r;
  logic [30:0]                     f0_ysq_r;
  logic [30:0]                     f0_zsq_r;
  logic                            f1_v_r;
  logic                            f1_rdy;
  atp_pkg::root_t                  f1_d_r;
  logic [atp_pkg::SUM_W-1:0]       f1_sum;

  assign in_x     = signed'(in_tdata[15:0]);
  assign in_y     = signed'(in_tdata[31:16]);
  assign in_z     = signed'(in_tdata[47:32]);
  assign ysq_full = 32'(in_y) * 32'(in_y);
  assign zsq_full = 32'(in_z) * 32'(in_z);
  assign in_tready = f0_rdy;
  assign f0_rdy   = !f0_v_r || f1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
    end else if (f0_rdy) begin
      f0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (f0_rdy && in_tvalid) begin
      f0_x_r   <= in_x;
      f0_ysq_r <= ysq_full[30:0];
      f0_zsq_r <= zsq_full[30:0];
    end
  end

  // sum of squares, seeds the root chain
  logic sq_v   [NR+1];
  logic sq_rdy [NR+1];
  atp_pkg::root_t sq_d [NR+1];

  assign f1_sum = atp_pkg::SUM_W'(f0_ysq_r) + atp_pkg::SUM_W'(f0_zsq_r);
  assign f1_rdy = !f1_v_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_rdy) begin
      f1_v_r <= f0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && f0_v_r) begin
      f1_d_r.x    <= f0_x_r;
      f1_d_r.zero <= (f1_sum == '0);
      f1_d_r.s    <= f1_sum;
      f1_d_r.rem  <= '0;
      f1_d_r.root <= '0;
    end
  end

  assign sq_v[0] = f1_v_r;
  assign sq_d[0] = f1_d_r;

  // root of sum * 2^16: sqrt with 8 fraction bits
  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    atp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[i]),
      .up_ready (sq_rdy[i]),
      .up_data  (sq_d[i]),
      .dn_valid (sq_v[i+1]),
      .dn_ready (sq_rdy[i+1]),
      .dn_data  (sq_d[i+1])
    );
  end

  // CORDIC chain starting from (root, x*256)
  logic cd_v   [NC+1];
  logic cd_rdy [NC+1];
  atp_pkg::cord_t cd_d [NC+1];

  assign cd_v[0]       = sq_v[NR];
  assign sq_rdy[NR]    = cd_rdy[0];
  assign cd_d[0].cx    = signed'(atp_pkg::CW'(sq_d[NR].root));
  assign cd_d[0].cy    = signed'({{(atp_pkg::CW-atp_pkg::IN_W-8){sq_d[NR].x[atp_pkg::IN_W-1]}},
                                  sq_d[NR].x, 8'd0});
  assign cd_d[0].acc   = '0;
  assign cd_d[0].zero  = sq_d[NR].zero;
  assign cd_d[0].xneg  = sq_d[NR].x[atp_pkg::IN_W-1];
  assign cd_d[0].xnz   = (sq_d[NR].x != '0);

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    atp_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (atp_pkg::IDX_W'(i)),
      .up_valid  (cd_v[i]),
      .up_ready  (cd_rdy[i]),
      .up_data   (cd_d[i]),
      .dn_valid  (cd_v[i+1]),
      .dn_ready  (cd_rdy[i+1]),
      .dn_data   (cd_d[i+1])
    );
  end

  // p0: round, clamp, whole degrees
  logic signed [atp_pkg::ACC_W-1:0]  rnd;
  logic signed [atp_pkg::FINE_W-1:0] fine_c;
  logic signed [atp_pkg::FINE_W-1:0] deg_wide;
  logic signed [atp_pkg::DEG_W-1:0]  deg_c;
  logic                              p0_v_r;
  logic                              p0_rdy;
  logic                              p1_rdy;
  logic                              p2_rdy;
  logic                              p3_rdy;
  logic signed [atp_pkg::FINE_W-1:0] p0_fine_r;
  logic signed [atp_pkg::DEG_W-1:0]  p0_deg_r;
  logic [atp_pkg::PDEG_W-1:0]        p0_pdeg_r;

  always_comb begin
    rnd = (cd_d[NC].acc + atp_pkg::ACC_W'(128)) >>> 8;
    if (cd_d[NC].zero) begin
      // y and z both zero: straight up, straight down, or no reading
      if (!cd_d[NC].xnz) begin
        fine_c = '0;
      end else if (cd_d[NC].xneg) begin
        fine_c = -atp_pkg::FINE_LIMIT;
      end else begin
        fine_c = atp_pkg::FINE_LIMIT;
      end
    end else if (rnd > atp_pkg::ACC_W'(atp_pkg::FINE_LIMIT)) begin
      fine_c = atp_pkg::FINE_LIMIT;
    end else if (rnd < -atp_pkg::ACC_W'(atp_pkg::FINE_LIMIT)) begin
      fine_c = -atp_pkg::FINE_LIMIT;
    end else begin
      fine_c = rnd[atp_pkg::FINE_W-1:0];
    end
    // truncate towards zero
    deg_wide = (fine_c + (fine_c[atp_pkg::FINE_W-1] ? 16'sd255 : 16'sd0)) >>> 8;
    deg_c    = deg_wide[atp_pkg::DEG_W-1:0];
  end

  assign p0_rdy     = !p0_v_r || p1_rdy;
  assign cd_rdy[NC] = p0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (p0_rdy) begin
      p0_v_r <= cd_v[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (p0_rdy && cd_v[NC]) begin
      p0_fine_r <= fine_c;
      p0_deg_r  <= deg_c;
      p0_pdeg_r <= deg_c[atp_pkg::DEG_W-1] ? '0 : deg_c[atp_pkg::PDEG_W-1:0];
    end
  end

  // p1: deg * span
  logic                              p1_v_r;
  logic signed [atp_pkg::FINE_W-1:0] p1_fine_r;
  logic signed [atp_pkg::DEG_W-1:0]  p1_deg_r;
  logic [atp_pkg::PROD_W-1:0]        p1_prod_r;

  assign p1_rdy = !p1_v_r || p2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_r <= p0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && p0_v_r) begin
      p1_fine_r <= p0_fine_r;
      p1_deg_r  <= p0_deg_r;
      p1_prod_r <= atp_pkg::PROD_W'(p0_pdeg_r) * atp_pkg::PROD_W'(pulse_span_r);
    end
  end

  // p2: divide by 180 through the reciprocal
  logic [atp_pkg::PROD_W+atp_pkg::RECIP_W-1:0] qfull;
  logic                              p2_v_r;
  logic signed [atp_pkg::FINE_W-1:0] p2_fine_r;
  logic signed [atp_pkg::DEG_W-1:0]  p2_deg_r;
  logic [atp_pkg::US_W-1:0]          p2_q_r;

  assign qfull  = (atp_pkg::PROD_W+atp_pkg::RECIP_W)'(p1_prod_r) *
                  (atp_pkg::PROD_W+atp_pkg::RECIP_W)'(atp_pkg::RECIP_180);
  assign p2_rdy = !p2_v_r || p3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_v_r) begin
      p2_fine_r <= p1_fine_r;
      p2_deg_r  <= p1_deg_r;
      p2_q_r    <= qfull[atp_pkg::RECIP_SH +: atp_pkg::US_W];
    end
  end

  // p3: add the offset, saturate, output register
  logic [atp_pkg::US_W:0]            psum;
  logic                              p3_v_r;
  logic signed [atp_pkg::FINE_W-1:0] p3_fine_r;
  logic signed [atp_pkg::DEG_W-1:0]  p3_deg_r;
  logic [atp_pkg::US_W-1:0]          p3_pulse_r;

  assign psum   = {1'b0, pulse_min_r} + {1'b0, p2_q_r};
  assign p3_rdy = !p3_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (p3_rdy) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_rdy && p2_v_r) begin
      p3_fine_r  <= p2_fine_r;
      p3_deg_r   <= p2_deg_r;
      p3_pulse_r <= psum[atp_pkg::US_W] ? '1 : psum[atp_pkg::US_W-1:0];
    end
  end

  assign out_tvalid = p3_v_r;
  assign out_tdata  = {p3_pulse_r, p3_deg_r, p3_fine_r};

  // checks
  a_fine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (p3_fine_r <= atp_pkg::FINE_LIMIT) && (p3_fine_r >= -atp_pkg::FINE_LIMIT))
    else $error("tilt_fine outside +/-90 degrees");

  a_pulse_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (p3_pulse_r >= pulse_min_r))
    else $error("pulse below pulse_min");

  a_neg_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (p3_deg_r <= 0)) |-> (p3_pulse_r == pulse_min_r))
    else $error("non-positive tilt must give pulse_min");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with the output free");

endmodule

FILE: verif/testbench.sv
module testbench;

  localparam int SAMPLE_W    = 16;
  localparam int TILT_STAGES = (atp_pkg::CORDIC_STAGES > 24) ? 24 : atp_pkg::CORDIC_STAGES;
  localparam longint TILT_MAX = 23040;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 200;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [atp_pkg::FINE_W-1:0] fine;
    logic signed [atp_pkg::DEG_W-1:0]  deg;
    logic [atp_pkg::US_W-1:0]          pulse;
  } tilt_result_t;

  typedef struct packed {
    sample_t      smp;
    logic         known;
    tilt_result_t res;
  } tilt_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // accel_x, accel_y, accel_z
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // tilt_fine, tilt_deg, pulse_us
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  logic [15:0]  pulse_min_q;
  logic [15:0]  pulse_span_q;
  tilt_result_t pending_tilt [$];
  int           error_count;
  int           result_count;
  bit           no_idle;
  bit           hold_off_req;
  tilt_row_t    dir_rows [DIR_ROWS];

  // atan(2^-i) in 2^-16 degree
  longint atan_lut [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  accel_tilt_to_servo_pulse DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("[accel_tilt_to_servo_pulse] ERROR");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b    = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v    = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic tilt_result_t predict_tilt(input sample_t s, input logic [15:0] min_us,
                                                input logic [15:0] span_us);
    tilt_result_t    r;
    longint          xs, ys, zs, cx, cy, dx, dy, acc, fine, deg, pdeg, pulse;
    longint unsigned sq;
    xs  = longint'(s.x);
    ys  = longint'(s.y);
    zs  = longint'(s.z);
    acc = 0;
    sq  = longint'(ys * ys) + longint'(zs * zs);
    if (sq == 0) begin
      fine = (xs > 0) ? TILT_MAX : ((xs < 0) ? -TILT_MAX : 0);
    end else begin
      cx = longint'(int_sqrt(sq << 16));
      cy = xs * 256;
      for (int i = 0; i < TILT_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx  = cx + dx;
          cy  = cy - dy;
          acc = acc + atan_lut[i];
        end else begin
          cx  = cx - dx;
          cy  = cy + dy;
          acc = acc - atan_lut[i];
        end
      end
      fine = (acc + 128) >>> 8;
      if (fine > TILT_MAX) fine = TILT_MAX;
      if (fine < -TILT_MAX) fine = -TILT_MAX;
    end
    deg  = fine / 256;
    pdeg = deg;
    if (pdeg < 0) pdeg = 0;
    if (pdeg > 180) pdeg = 180;
    pulse = longint'(min_us) + (pdeg * longint'(span_us)) / 180;
    if (pulse > 65535) pulse = 65535;
    r.fine  = fine[15:0];
    r.deg   = deg[7:0];
    r.pulse = pulse[15:0];
    return r;
  endfunction

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic sample_t rand_sample();
    sample_t     s;
    logic [15:0] corner [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    s.x = SAMPLE_W'($urandom);
    s.y = SAMPLE_W'($urandom);
    s.z = SAMPLE_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin  // y and z zero: vertical or all-zero
        s.y = '0;
        s.z = '0;
        if ($urandom_range(0, 3) == 0) s.x = '0;
      end
      1: begin
        s.x = SAMPLE_W'($urandom_range(0, 63) - 32);
        s.y = SAMPLE_W'($urandom_range(0, 63) - 32);
        s.z = SAMPLE_W'($urandom_range(0, 63) - 32);
      end
      2: begin
        s.x = corner[$urandom_range(0, 4)];
        s.y = corner[$urandom_range(0, 4)];
        s.z = corner[$urandom_range(0, 4)];
      end
      3: begin  // near vertical
        s.y = SAMPLE_W'($urandom_range(0, 7) - 4);
        s.z = SAMPLE_W'($urandom_range(0, 7) - 4);
      end
      4: s.x = '0;
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_result(input tilt_result_t got);
    tilt_result_t want;
    result_count++;
    if (pending_tilt.size() == 0) begin
      report_mismatch($sformatf("result %0d with no request outstanding", result_count));
    end else begin
      want = pending_tilt.pop_front();
      if (got.fine !== want.fine)
        report_mismatch($sformatf("result %0d tilt_fine %0d, want %0d",
                                  result_count, got.fine, want.fine));
      if (got.deg !== want.deg)
        report_mismatch($sformatf("result %0d tilt_deg %0d, want %0d",
                                  result_count, got.deg, want.deg));
      if (got.pulse !== want.pulse)
        report_mismatch($sformatf("result %0d pulse_us %0d, want %0d",
                                  result_count, got.pulse, want.pulse));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result('{fine: out_tdata[15:0], deg: out_tdata[23:16], pulse: out_tdata[39:24]});
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input sample_t s, input logic known, input tilt_result_t typed_res);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.z, s.y, s.x};
    do @(posedge clk); while (!in_tready);
    if (known) pending_tilt.push_back(typed_res);
    else pending_tilt.push_back(predict_tilt(s, pulse_min_q, pulse_span_q));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tilt.size() != 0);
  endtask

  task automatic write_cfg(input logic [15:0] min_us, input logic [15:0] span_us);
    cfg_we    <= 1'b1;
    cfg_addr  <= atp_pkg::REG_PULSE_MIN;
    cfg_wdata <= min_us;
    @(posedge clk);
    cfg_addr  <= atp_pkg::REG_PULSE_SPAN;
    cfg_wdata <= span_us;
    @(posedge clk);
    cfg_we <= 1'b0;
    pulse_min_q  = min_us;
    pulse_span_q = span_us;
  endtask

  initial begin
    logic [15:0] phase_min  [PHASES];
    logic [15:0] phase_span [PHASES];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = atp_pkg::REG_PULSE_MIN;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    error_count  = 0;
    result_count = 0;
    pulse_min_q  = atp_pkg::PULSE_MIN_RST;
    pulse_span_q = atp_pkg::PULSE_SPAN_RST;

    // rows with a typed result assume the reset pulse settings
    dir_rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0},            1'b1, '{16'sd0, 8'sd0, 16'd1000}},
      '{'{16'sd1, 16'sd0, 16'sd0},            1'b1, '{16'sd23040, 8'sd90, 16'd1500}},
      '{'{-16'sd1, 16'sd0, 16'sd0},           1'b1, '{-16'sd23040, -8'sd90, 16'd1000}},
      '{'{16'sd32767, 16'sd0, 16'sd0},        1'b1, '{16'sd23040, 8'sd90, 16'd1500}},
      '{'{-16'sd32768, 16'sd0, 16'sd0},       1'b1, '{-16'sd23040, -8'sd90, 16'd1000}},
      '{'{16'sd0, 16'sd1, 16'sd0},            1'b0, '0},
      '{'{16'sd0, -16'sd32768, -16'sd32768},  1'b0, '0},
      '{'{16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, '0},
      '{'{-16'sd32768, 16'sd32767, 16'sd32767},  1'b0, '0},
      '{'{16'sd32767, 16'sd1, 16'sd0},        1'b0, '0},
      '{'{-16'sd32768, 16'sd0, 16'sd1},       1'b0, '0},
      '{'{16'sd100, 16'sd0, 16'sd100},        1'b0, '0},
      '{'{-16'sd100, 16'sd100, 16'sd0},       1'b0, '0},
      '{'{16'sd1, -16'sd1, 16'sd0},           1'b0, '0},
      '{'{16'sd10000, 16'sd17321, 16'sd0},    1'b0, '0},
      '{'{-16'sd32768, -16'sd32768, 16'sd0},  1'b0, '0},
      '{'{16'sd32767, 16'sd32767, 16'sd32767},   1'b0, '0},
      '{'{16'sd21845, -16'sd21846, 16'sd21845},  1'b0, '0},
      '{'{16'sd0, 16'sd0, -16'sd32768},       1'b0, '0},
      '{'{16'sd12345, -16'sd6789, 16'sd222},  1'b0, '0}
    };

    phase_min  = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd1500, 16'd0};
    phase_span = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1000, 16'd0};
    phase_min[4]  = 16'($urandom);
    phase_span[4] = 16'($urandom);
    phase_min[6]  = 16'($urandom_range(0, 3000));
    phase_span[6] = 16'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_cfg(phase_min[p], phase_span[p]);
      // phase 4: back-to-back requests while the result side holds off
      no_idle = (p == 4);
      if (p == 4) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(rand_sample(), 1'b0, '0);
    end
    wait_drained();
    repeat (60) @(posedge clk);

    if (error_count == 0) begin
      $display("[accel_tilt_to_servo_pulse] OK");
    end else begin
      $display("[accel_tilt_to_servo_pulse] ERROR");
    end
    $finish;
  end

endmodule
